[rtl/core/ssmr_pkg.sv]
// Shared types and constants of the strobed serial message receiver.
package ssmr_pkg;

    localparam int TIMEOUT_W = 16;
    localparam int BIT_POS_W = 3;
    localparam int BYTE_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIMEOUT_W-1:0] FIRST_BIT_TIMEOUT_RST = 16'd5000;
    localparam logic [TIMEOUT_W-1:0] BIT_GAP_TIMEOUT_RST   = 16'd500;
    localparam logic [BIT_POS_W-1:0] LAST_BIT_POS          = 3'd7;
    localparam logic [BYTE_W-1:0]    ERROR_BYTE            = 8'hff;
    localparam int                   END_MARK_BIT          = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_BIT_TIMEOUT = 1'b0,
        CFG_BIT_GAP_TIMEOUT   = 1'b1
    } t_cfg_idx;

    // One word passed from the front end to the output stage.
    typedef struct packed {
        logic              timeout;
        logic [BYTE_W-1:0] raw_byte;
    } t_event;

endpackage

[rtl/core/ssmr_in_if.sv]
// Input sample channel: strobe, data and millisecond tick.
interface ssmr_in_if;
    logic valid;
    logic ready;
    logic strobe_level;
    logic data_level;
    logic ms_tick;

    modport source (output valid, output strobe_level, output data_level,
                    output ms_tick, input ready);
    modport sink (input valid, input strobe_level, input data_level,
                  input ms_tick, output ready);
endinterface

[rtl/core/ssmr_out_if.sv]
// Result channel: received character, end-of-message flag and error flag.
interface ssmr_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] data_byte;
    logic       last_in_message;
    logic       error;

    modport source (output valid, output data_byte, output last_in_message,
                    output error, input ready);
    modport sink (input valid, input data_byte, input last_in_message,
                  input error, output ready);
endinterface

[rtl/core/ssmr_front.sv]
// Front end: strobe edge detection, bit shifting and millisecond timeouts.
module ssmr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssmr_pkg::TIMEOUT_W-1:0] i_cfg_data,
    ssmr_in_if.sink                        i_in,
    input  logic                           i_full,
    output logic                           o_push,
    output ssmr_pkg::t_event               o_event
);
    import ssmr_pkg::*;

    logic [TIMEOUT_W-1:0] r_first_limit, n_first_limit;
    logic [TIMEOUT_W-1:0] r_gap_limit, n_gap_limit;
    logic                 r_prev_strobe, n_prev_strobe;
    logic [BIT_POS_W-1:0] r_bit_pos, n_bit_pos;
    logic [BYTE_W-1:0]    r_shift, n_shift;
    logic [TIMEOUT_W-1:0] r_elapsed, n_elapsed;

    logic                 accept;
    logic                 rising;
    logic [BYTE_W-1:0]    shifted;
    logic [TIMEOUT_W-1:0] limit;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign rising     = i_in.strobe_level && !r_prev_strobe;
    assign shifted    = r_shift | (BYTE_W'(i_in.data_level) << r_bit_pos);
    assign limit      = (r_bit_pos == '0) ? r_first_limit : r_gap_limit;

    always_comb begin
        n_first_limit = r_first_limit;
        n_gap_limit   = r_gap_limit;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_BIT_TIMEOUT: n_first_limit = i_cfg_data;
                CFG_BIT_GAP_TIMEOUT:   n_gap_limit   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_prev_strobe    = r_prev_strobe;
        n_bit_pos        = r_bit_pos;
        n_shift          = r_shift;
        n_elapsed        = r_elapsed;
        o_push           = 1'b0;
        o_event.timeout  = 1'b0;
        o_event.raw_byte = shifted;
        if (accept) begin
            n_prev_strobe = i_in.strobe_level;
            // An edge takes priority over a tick arriving in the same sample.
            priority if (rising) begin
                n_elapsed = '0;
                if (r_bit_pos == LAST_BIT_POS) begin
                    o_push    = 1'b1;
                    n_bit_pos = '0;
                    n_shift   = '0;
                end else begin
                    n_bit_pos = r_bit_pos + 1'b1;
                    n_shift   = shifted;
                end
            end else if (i_in.ms_tick) begin
                if (r_elapsed >= limit) begin
                    o_push          = 1'b1;
                    o_event.timeout = 1'b1;
                    n_bit_pos       = '0;
                    n_shift         = '0;
                    n_elapsed       = '0;
                end else begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end else begin
                // Neither an edge nor a tick: the count holds.
                n_elapsed = r_elapsed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_limit <= FIRST_BIT_TIMEOUT_RST;
            r_gap_limit   <= BIT_GAP_TIMEOUT_RST;
            r_prev_strobe <= 1'b0;
            r_bit_pos     <= '0;
            r_shift       <= '0;
            r_elapsed     <= '0;
        end else begin
            r_first_limit <= n_first_limit;
            r_gap_limit   <= n_gap_limit;
            r_prev_strobe <= n_prev_strobe;
            r_bit_pos     <= n_bit_pos;
            r_shift       <= n_shift;
            r_elapsed     <= n_elapsed;
        end
    end

endmodule

[rtl/core/ssmr_queue.sv]
// Short word queue between the front end and the output stage.
module ssmr_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ssmr_pkg::t_event i_event,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_avail,
    output ssmr_pkg::t_event o_event
);
    import ssmr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_event             r_entries [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_avail = (r_count != '0);
    assign o_event = r_entries[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/ssmr_back.sv]
// Output stage: turns queued words into result fields and holds them.
module ssmr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  ssmr_pkg::t_event i_event,
    output logic             o_pop,
    ssmr_out_if.source       o_out
);
    import ssmr_pkg::*;

    logic              r_valid, n_valid;
    logic [CHAR_W-1:0] r_data;
    logic              r_last;
    logic              r_error;
    logic              is_error;

    // A received all-ones byte is reported the same way as a timeout.
    assign is_error = i_event.timeout || (i_event.raw_byte == ERROR_BYTE);
    assign o_pop    = i_avail && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data  <= is_error ? '0 : i_event.raw_byte[CHAR_W-1:0];
            r_last  <= is_error || i_event.raw_byte[END_MARK_BIT];
            r_error <= is_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.data_byte       = r_data;
    assign o_out.last_in_message = r_last;
    assign o_out.error           = r_error;

endmodule

[rtl/core/strobed_serial_message_receiver.sv]
// Top level of the strobed serial message receiver.
//
//  Channel   Direction  Handshake      Payload
//  i_in      in         valid/ready    strobe_level, data_level, ms_tick
//  o_out     out        valid/ready    data_byte, last_in_message, error
//  i_cfg_*   in         write enable   idx 0 first-bit limit, idx 1 gap limit
//
// One sample word is taken every cycle while the queue has room; a completed
// byte or timeout is registered in the queue, then in the output register.
// Reset (synchronous, active low) restores the default limits and clears the
// shift state. While o_out is stalled the queue of QUEUE_DEPTH words absorbs
// results; i_in.ready drops only once that queue is full.
module strobed_serial_message_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssmr_pkg::TIMEOUT_W-1:0] i_cfg_data,
    ssmr_in_if.sink                        i_in,
    ssmr_out_if.source                     o_out
);
    import ssmr_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   avail;
    t_event front_event;
    t_event queue_event;

    ssmr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_event    (front_event)
    );

    ssmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (front_event),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_event (queue_event)
    );

    ssmr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_event (queue_event),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[test/ssmr_tb_pkg.sv]
`timescale 1ns / 100ps
// Result word type and scoreboard class for the strobed serial message receiver bench.
package ssmr_tb_pkg;

    import ssmr_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              last_in_message;
        logic              error;
    } rx_word_t;

    class message_scoreboard;
        logic [TIMEOUT_W-1:0] first_limit;
        logic [TIMEOUT_W-1:0] gap_limit;
        logic                 prev_strobe;
        logic [BIT_POS_W-1:0] bit_pos;
        logic [BYTE_W-1:0]    shift_reg;
        logic [TIMEOUT_W-1:0] elapsed_ms;
        rx_word_t             expected_words[$];
        int                   failures;
        int                   words_checked;
        int                   chars_seen;
        int                   messages_ended;
        int                   bad_bytes;
        int                   timeouts;

        function new();
            first_limit = FIRST_BIT_TIMEOUT_RST;
            gap_limit   = BIT_GAP_TIMEOUT_RST;
            prev_strobe = 1'b0;
            restart_byte();
            failures       = 0;
            words_checked  = 0;
            chars_seen     = 0;
            messages_ended = 0;
            bad_bytes      = 0;
            timeouts       = 0;
        endfunction

        function void restart_byte();
            bit_pos    = '0;
            shift_reg  = '0;
            elapsed_ms = '0;
        endfunction

        function void write_limit(t_cfg_idx idx, logic [TIMEOUT_W-1:0] value);
            case (idx)
                CFG_FIRST_BIT_TIMEOUT: first_limit = value;
                CFG_BIT_GAP_TIMEOUT:   gap_limit   = value;
                default: ;
            endcase
        endfunction

        function void push_error();
            rx_word_t w;
            w.data_byte       = '0;
            w.last_in_message = 1'b1;
            w.error           = 1'b1;
            expected_words.push_back(w);
        endfunction

        // Advances the receiver state by one accepted sample word.
        function void note_sample(logic strobe, logic data, logic tick);
            logic                 rising;
            logic [TIMEOUT_W-1:0] limit;
            logic [BYTE_W-1:0]    got;
            rx_word_t             w;
            rising      = strobe && !prev_strobe;
            prev_strobe = strobe;
            if (rising) begin
                if (data)
                    shift_reg[bit_pos] = 1'b1;
                elapsed_ms = '0;
                if (bit_pos == LAST_BIT_POS) begin
                    got = shift_reg;
                    restart_byte();
                    if (got == ERROR_BYTE) begin
                        bad_bytes++;
                        push_error();
                    end else begin
                        w.data_byte       = got[CHAR_W-1:0];
                        w.last_in_message = got[END_MARK_BIT];
                        w.error           = 1'b0;
                        chars_seen++;
                        if (w.last_in_message)
                            messages_ended++;
                        expected_words.push_back(w);
                    end
                end else begin
                    bit_pos = bit_pos + 1'b1;
                end
            end else if (tick) begin
                limit = (bit_pos == '0) ? first_limit : gap_limit;
                if (elapsed_ms >= limit) begin
                    restart_byte();
                    timeouts++;
                    push_error();
                end else begin
                    elapsed_ms = elapsed_ms + 1'b1;
                end
            end
        endfunction

        function void check_word(logic [CHAR_W-1:0] data_byte, logic last_in_message,
                                 logic error);
            rx_word_t want;
            if (expected_words.size() == 0) begin
                $error("result word with none expected: data_byte=%0h last=%0b error=%0b",
                       data_byte, last_in_message, error);
                failures++;
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (data_byte !== want.data_byte) begin
                $error("data_byte: expected %0h, actual %0h", want.data_byte, data_byte);
                failures++;
            end
            if (last_in_message !== want.last_in_message) begin
                $error("last_in_message: expected %0b, actual %0b",
                       want.last_in_message, last_in_message);
                failures++;
            end
            if (error !== want.error) begin
                $error("error: expected %0b, actual %0b", want.error, error);
                failures++;
            end
        endfunction

        function int words_pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

[test/strobed_serial_message_receiver_tb.sv]
`timescale 1ns / 100ps
// Top-level bench: drives line samples and limit writes, checks every result word.
module strobed_serial_message_receiver_tb;

    import ssmr_pkg::*;
    import ssmr_tb_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_HOLD       = 200;
    localparam int PHASE_SAMPLES   = 100;
    localparam int TOTAL_SAMPLES   = 820;
    localparam int CYCLE_LIMIT     = 300000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TIMEOUT_W-1:0] i_cfg_data;

    ssmr_in_if  in_ch();
    ssmr_out_if out_ch();

    strobed_serial_message_receiver uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    message_scoreboard sb = new();

    bit                   tx_gaps   = 1'b0;
    bit                   rx_stalls = 1'b0;
    bit                   long_hold = 1'b0;
    int                   tick_pct  = 30;
    int                   samples_sent = 0;
    int                   cycle_count  = 0;
    logic [TIMEOUT_W-1:0] first_cfg = FIRST_BIT_TIMEOUT_RST;
    logic [TIMEOUT_W-1:0] gap_cfg   = BIT_GAP_TIMEOUT_RST;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Both handshakes and limit writes are observed at the same edge the block sees them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_limit(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (out_ch.valid && out_ch.ready)
                sb.check_word(out_ch.data_byte, out_ch.last_in_message, out_ch.error);
            if (in_ch.valid && in_ch.ready)
                sb.note_sample(in_ch.strobe_level, in_ch.data_level, in_ch.ms_tick);
        end
    end

    function automatic int pick_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic rand_tick();
        return $urandom_range(0, 99) < tick_pct;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return ERROR_BYTE;
            1:       return 8'h00;
            2:       return 8'h7f;
            3:       return 8'h80;
            4:       return 8'hfe;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result sink: random stalls, plus one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
                out_ch.ready <= 1'b0;
                repeat (pick_len() - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic strobe, input logic data, input logic tick);
        if (tx_gaps && $urandom_range(0, 99) < 20) begin
            in_ch.valid <= 1'b0;
            repeat (pick_len()) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.strobe_level <= strobe;
        in_ch.data_level   <= data;
        in_ch.ms_tick      <= tick;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
        samples_sent++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_sample(1'b0, rand_bit(), 1'b1);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_sample(rand_bit(), rand_bit(), rand_tick());
    endtask

    task automatic send_char(input logic [BYTE_W-1:0] value);
        for (int i = 0; i < BYTE_W; i++) begin
            repeat ($urandom_range(1, 3)) send_sample(1'b0, rand_bit(), rand_tick());
            send_sample(1'b1, value[i], rand_tick());
            if ($urandom_range(0, 3) == 0)
                send_sample(1'b1, rand_bit(), rand_tick());
        end
    endtask

    // One to seven bits; then, for a gap limit up to 40, the strobe goes quiet until it runs out, else noise follows.
    task automatic abandon_char();
        int bits;
        bits = $urandom_range(1, 7);
        repeat (bits) begin
            send_sample(1'b0, rand_bit(), rand_tick());
            send_sample(1'b1, rand_bit(), rand_tick());
        end
        if (gap_cfg <= 40)
            run_ticks(int'(gap_cfg) + 1);
        else
            send_noise($urandom_range(1, 6));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.words_pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [TIMEOUT_W-1:0] first_ms,
                              input logic [TIMEOUT_W-1:0] gap_ms);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_BIT_TIMEOUT;
        i_cfg_data <= first_ms;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_BIT_GAP_TIMEOUT;
        i_cfg_data <= gap_ms;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        first_cfg = first_ms;
        gap_cfg   = gap_ms;
    endtask

    initial begin
        int phase;
        int phase_end;
        int r;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_FIRST_BIT_TIMEOUT;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.strobe_level = 1'b0;
        in_ch.data_level   = 1'b0;
        in_ch.ms_tick      = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Strobe already high on the first sample is an edge; an edge with a tick
        // restarts the count. All ones in the byte is reported as an error.
        send_sample(1'b1, 1'b1, 1'b1);
        for (int i = 1; i < BYTE_W; i++) begin
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b1, 1'b1, 1'(i % 2));
        end
        settle();
        // A zero limit times out on the very next tick.
        set_limits(16'd0, 16'hffff);
        run_ticks(1);
        settle();
        // Idle line: an error each time the first-bit limit runs out.
        set_limits(16'd2, 16'd1);
        run_ticks(6);
        settle();

        phase = 0;
        while (samples_sent < TOTAL_SAMPLES) begin
            settle();
            case (phase % 8)
                0: set_limits(FIRST_BIT_TIMEOUT_RST, BIT_GAP_TIMEOUT_RST);
                1: set_limits(16'd1, 16'd1);
                2: set_limits(16'hffff, 16'hffff);
                3: set_limits(16'd4, 16'd2);
                4: set_limits(16'd0, 16'd1);
                5: set_limits(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
                6: set_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
                default: set_limits(16'd2, 16'hffff);
            endcase
            tx_gaps   = (phase % 3) != 0;
            rx_stalls = (phase % 2) == 1;
            tick_pct  = (first_cfg <= 4 || gap_cfg <= 4) ? 15 : 45;
            if (phase % 8 == 2) begin
                // Sender keeps streaming while the sink holds off, so the block backs up.
                tx_gaps   = 1'b0;
                long_hold = 1'b1;
            end
            phase_end = samples_sent + PHASE_SAMPLES;
            while (samples_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    send_char(pick_char());
                else if (r < 72)
                    abandon_char();
                else if (r < 82 && first_cfg <= 40)
                    run_ticks(int'(first_cfg) + 1);
                else
                    send_noise($urandom_range(1, 12));
            end
            phase++;
        end
        settle();

        $display("Ran %0d sample words over %0d limit settings; %0d result words checked.",
                 samples_sent, phase + 3, sb.words_checked);
        $display("Results: %0d characters (%0d ending a message), %0d bad bytes, %0d timeouts.",
                 sb.chars_seen, sb.messages_ended, sb.bad_bytes, sb.timeouts);
        if (sb.failures == 0 && sb.words_pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
